[hdl/gtm_pkg.sv]
// shared types and constants for the greedy threshold matcher
package gtm_pkg;

    localparam int DEF_MAX_ENTRIES = 1024;
    localparam int VALUE_W         = 16;
    localparam int COUNT_W         = 11;

    localparam logic OP_THRESHOLD = 1'b0;
    localparam logic OP_SUPPLY    = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [VALUE_W-1:0] item_value;
        logic               last_item;
    } in_beat_t;

    typedef struct packed {
        logic [COUNT_W-1:0] match_count;
        logic               overflow;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_INIT,
        ST_KEY_RD,
        ST_KEY_LATCH,
        ST_CMP_RD,
        ST_CMP,
        ST_PLACE,
        ST_MATCH_INIT,
        ST_MATCH_RD,
        ST_MATCH_CMP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic sel_sup;
        logic k_init;
        logic key_rd;
        logic key_latch;
        logic cmp_rd;
        logic shift;
        logic place;
        logic match_init;
        logic match_rd;
        logic match_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic k_done;
        logic pos_zero;
        logic gt;
        logic match_done;
        logic out_busy;
    } status_t;

endpackage

[hdl/greedy_threshold_matcher_top.sv]
// Greedy threshold matcher, top level.
// Input channel s_: one beat loads a demand threshold (operation 0) or a
// supply value (operation 1) into its list; each list holds MAX_ENTRIES
// values and loads beyond that are dropped and flagged as overflow.
// A beat with last_item set is loaded and then starts the batch: both lists
// are insertion sorted in place in their rams, then walked together.
// Load beats are taken back to back. After the last beat s_ready stays low
// while the threshold list and then the supply list are sorted (each element
// is read as the key, each larger value before it is shifted up by one place,
// then the key is placed) and the lists are walked, and until the result
// enters the result register. The rams have a single read port each, so both
// the sort and the walk read one address of a list at a time.
// Result channel m_: one beat per batch with match_count and overflow; it
// sits in a register, so loads of the next batch are taken while it waits.
// A stalled receiver only blocks the end of the following batch.
// Reset (aresetn low, synchronous) empties both lists, clears overflow and
// drops any pending result; ram contents are not cleared.
module greedy_threshold_matcher_top #(
    parameter int MAX_ENTRIES = gtm_pkg::DEF_MAX_ENTRIES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  gtm_pkg::in_beat_t  s_beat,
    output logic               m_valid,
    input  logic               m_ready,
    output gtm_pkg::out_beat_t m_beat
);
    import gtm_pkg::*;

    cmd_t    cmd;
    status_t status;

    gtm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .last_item(s_beat.last_item),
        .status   (status),
        .cmd      (cmd)
    );

    gtm_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_beat (s_beat),
        .cmd    (cmd),
        .status (status),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_beat (m_beat)
    );
endmodule

[hdl/gtm_ram.sv]
// generic simple dual-port ram with registered read
module gtm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

[hdl/gtm_ctrl.sv]
// controller state machine: load, insertion sort of both lists, greedy match
module gtm_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             last_item,
    input  gtm_pkg::status_t status,
    output gtm_pkg::cmd_t    cmd
);
    import gtm_pkg::*;

    state_t state_reg, state_next;
    logic   sel_reg, sel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            sel_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        cmd         = '0;
        cmd.sel_sup = sel_reg;
        s_ready     = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid && last_item) begin
                    sel_next   = 1'b0;
                    state_next = ST_SORT_INIT;
                end
            end
            ST_SORT_INIT: begin
                cmd.k_init = 1'b1;
                state_next = ST_KEY_RD;
            end
            ST_KEY_RD: begin
                if (status.k_done) begin
                    if (!sel_reg) begin
                        sel_next   = 1'b1;
                        state_next = ST_SORT_INIT;
                    end else begin
                        state_next = ST_MATCH_INIT;
                    end
                end else begin
                    cmd.key_rd = 1'b1;
                    state_next = ST_KEY_LATCH;
                end
            end
            ST_KEY_LATCH: begin
                cmd.key_latch = 1'b1;
                state_next    = ST_CMP_RD;
            end
            ST_CMP_RD: begin
                if (status.pos_zero) begin
                    state_next = ST_PLACE;
                end else begin
                    cmd.cmp_rd = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (status.gt) begin
                    cmd.shift  = 1'b1;
                    state_next = ST_CMP_RD;
                end else begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE: begin
                cmd.place  = 1'b1;
                state_next = ST_KEY_RD;
            end
            ST_MATCH_INIT: begin
                cmd.match_init = 1'b1;
                state_next     = ST_MATCH_RD;
            end
            ST_MATCH_RD: begin
                if (status.match_done) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.match_rd = 1'b1;
                    state_next   = ST_MATCH_CMP;
                end
            end
            ST_MATCH_CMP: begin
                cmd.match_step = 1'b1;
                state_next     = ST_MATCH_RD;
            end
            ST_FINISH: begin
                if (!status.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end
endmodule

[hdl/gtm_dp.sv]
// datapath: list stores, counters, sort and match registers, result register
module gtm_dp #(
    parameter int MAX_ENTRIES = gtm_pkg::DEF_MAX_ENTRIES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  gtm_pkg::in_beat_t  s_beat,
    input  gtm_pkg::cmd_t      cmd,
    output gtm_pkg::status_t   status,
    output logic               m_valid,
    input  logic               m_ready,
    output gtm_pkg::out_beat_t m_beat
);
    import gtm_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_ENTRIES);

    logic [CW-1:0] thr_total_reg, sup_total_reg;
    logic          ovf_reg;
    logic [CW-1:0] k_reg, pos_reg, need_reg, have_reg;
    logic [VALUE_W-1:0] key_reg;
    logic          m_valid_reg;
    out_beat_t     m_beat_reg;

    logic               thr_we, sup_we;
    logic [AW-1:0]      thr_waddr, sup_waddr, thr_raddr, sup_raddr, sort_raddr, sort_waddr;
    logic [VALUE_W-1:0] sort_wdata, thr_wdata, sup_wdata;
    logic [VALUE_W-1:0] thr_rdata, sup_rdata, sel_rdata;
    logic [CW-1:0]      sel_total, pos_dec;
    logic               load_thr, load_sup, sort_we;

    assign load_thr = cmd.load && s_beat.operation == OP_THRESHOLD && thr_total_reg != FULL;
    assign load_sup = cmd.load && s_beat.operation == OP_SUPPLY && sup_total_reg != FULL;
    assign sort_we  = cmd.shift || cmd.place;
    assign pos_dec  = pos_reg - CW'(1);

    assign sel_rdata  = cmd.sel_sup ? sup_rdata : thr_rdata;
    assign sel_total  = cmd.sel_sup ? sup_total_reg : thr_total_reg;
    assign sort_raddr = cmd.key_rd ? k_reg[AW-1:0] : pos_dec[AW-1:0];
    assign sort_waddr = pos_reg[AW-1:0];
    assign sort_wdata = cmd.shift ? sel_rdata : key_reg;

    assign thr_we    = load_thr || (sort_we && !cmd.sel_sup);
    assign sup_we    = load_sup || (sort_we && cmd.sel_sup);
    assign thr_waddr = cmd.load ? thr_total_reg[AW-1:0] : sort_waddr;
    assign sup_waddr = cmd.load ? sup_total_reg[AW-1:0] : sort_waddr;
    assign thr_wdata = cmd.load ? s_beat.item_value : sort_wdata;
    assign sup_wdata = cmd.load ? s_beat.item_value : sort_wdata;
    assign thr_raddr = cmd.match_rd ? need_reg[AW-1:0] : sort_raddr;
    assign sup_raddr = cmd.match_rd ? have_reg[AW-1:0] : sort_raddr;

    gtm_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ENTRIES)) u_thr_ram (
        .aclk (aclk),
        .we   (thr_we),
        .waddr(thr_waddr),
        .wdata(thr_wdata),
        .raddr(thr_raddr),
        .rdata(thr_rdata)
    );

    gtm_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ENTRIES)) u_sup_ram (
        .aclk (aclk),
        .we   (sup_we),
        .waddr(sup_waddr),
        .wdata(sup_wdata),
        .raddr(sup_raddr),
        .rdata(sup_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_total_reg <= '0;
            sup_total_reg <= '0;
            ovf_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (load_thr) begin
                thr_total_reg <= thr_total_reg + CW'(1);
            end
            if (load_sup) begin
                sup_total_reg <= sup_total_reg + CW'(1);
            end
            if (cmd.load && !load_thr && !load_sup) begin
                ovf_reg <= 1'b1;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.finish) begin
                thr_total_reg <= '0;
                sup_total_reg <= '0;
                ovf_reg       <= 1'b0;
                m_valid_reg   <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.k_init) begin
            k_reg <= CW'(1);
        end else if (cmd.place) begin
            k_reg <= k_reg + CW'(1);
        end
        if (cmd.key_rd) begin
            pos_reg <= k_reg;
        end else if (cmd.shift) begin
            pos_reg <= pos_dec;
        end
        if (cmd.key_latch) begin
            key_reg <= sel_rdata;
        end
        if (cmd.match_init) begin
            need_reg <= '0;
            have_reg <= '0;
        end else if (cmd.match_step) begin
            have_reg <= have_reg + CW'(1);
            if (sup_rdata >= thr_rdata) begin
                need_reg <= need_reg + CW'(1);
            end
        end
        if (cmd.finish) begin
            m_beat_reg.match_count <= COUNT_W'(need_reg);
            m_beat_reg.overflow    <= ovf_reg;
        end
    end

    assign status.k_done     = k_reg >= sel_total;
    assign status.pos_zero   = pos_reg == '0;
    assign status.gt         = sel_rdata > key_reg;
    assign status.match_done = have_reg >= sup_total_reg || need_reg >= thr_total_reg;
    assign status.out_busy   = m_valid_reg && !m_ready;

    assign m_valid = m_valid_reg;
    assign m_beat  = m_beat_reg;
endmodule

[hdl/gtm_checker.sv]
// port-level checker for the greedy threshold matcher and its bind
module gtm_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input gtm_pkg::in_beat_t  s_beat,
    input logic               m_valid,
    input logic               m_ready,
    input gtm_pkg::out_beat_t m_beat
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_beat))
        else $error("result beat dropped or changed under stall");

    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_beat.last_item |=> !s_ready)
        else $error("input accepted during matching");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_no_result_while_loading: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a batch end");
endmodule

bind greedy_threshold_matcher_top gtm_checker u_gtm_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_beat (s_beat),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_beat (m_beat)
);
